// ----- sv/score_voting_classifier_top_macros.svh -----
// Assertion macros for the score voting classifier checker.
// Clock clk and active-low reset arst_n are taken from the enclosing scope.
`ifndef SCORE_VOTING_CLASSIFIER_TOP_MACROS_SVH
`define SCORE_VOTING_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, gated off during reset
`define SVC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off during reset
`define SVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/svc_pkg.sv -----
// Shared sizes, types and codes for the score voting classifier.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package svc_pkg;

	localparam int NUM_SOURCES = 4;
	localparam int QUEUE_DEPTH = 16;

	localparam int SCORE_W = 32;
	localparam int TIME_W  = 48;
	localparam int LABEL_W = 32;
	localparam int SIDX_W  = 2;
	localparam int REPS_W  = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int SRC_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	// wide enough for the source index and for the source count itself
	localparam int CNT_W   = $clog2(NUM_SOURCES + 1);
	localparam int SEL_W   = (CNT_W > SIDX_W) ? CNT_W : SIDX_W;
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRIES = NUM_SOURCES * QUEUE_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int ACC_W   = SCORE_W + QPTR_W;

	localparam logic [SCORE_W-1:0] ONE_Q16 = SCORE_W'(32'h0001_0000);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPETITIONS   = 3'd0,
		CFG_TARGET        = 3'd1,
		CFG_NONTARGET     = 3'd2,
		CFG_REJECT        = 3'd3,
		CFG_LABEL_BASE    = 3'd4,
		CFG_CHOOSE_FIRST  = 3'd5,
		CFG_VALUE_MODE    = 3'd6
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// Control from the sequencer to the accumulator
	typedef struct packed {
		logic             clr;
		logic             vld;
		logic             last;
		logic [SRC_W-1:0] src;
	} vote_ctl_t;

endpackage

// ----- sv/score_voting_classifier_top.sv -----
// Score voting classifier: per-source score queues in RAM, summed and voted by a
// shared accumulator. An input beat is taken in one cycle and checked the next;
// a beat that completes a round then walks each queue's round of scores through the
// single RAM read port and the accumulator at one entry per cycle, and the next
// beat is taken only once the decision has been loaded; a beat that completes no
// round lets the next beat in straight after its check.
// The decision waits in an output register, so the block goes back to taking
// beats while it is stalled, unless the next decision is ready first.
// Queue storage needs no clearing after reset: fill counts cover it.
// Depends on svc_pkg, svc_score, svc_vote and svc_ram.
`timescale 1ns / 1ps

module score_voting_classifier_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [svc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [svc_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic        [svc_pkg::SIDX_W-1:0]     source_index,
	input  logic signed [svc_pkg::SCORE_W-1:0]    value_first,
	input  logic signed [svc_pkg::SCORE_W-1:0]    value_second,
	input  logic                                  pair_valued,
	input  logic        [svc_pkg::LABEL_W-1:0]    label_code,
	input  logic        [svc_pkg::TIME_W-1:0]     time_stamp,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic        [svc_pkg::LABEL_W-1:0]    class_label,
	output logic        [svc_pkg::TIME_W-1:0]     decision_time,
	output logic                                  queue_overflowed
);

	localparam int NS = svc_pkg::NUM_SOURCES;
	localparam int QD = svc_pkg::QUEUE_DEPTH;
	localparam int FW = svc_pkg::FILL_W;
	localparam int PW = svc_pkg::QPTR_W;
	localparam int SW = svc_pkg::SRC_W;
	localparam int AW = svc_pkg::ADDR_W;
	localparam int RW = (svc_pkg::REPS_W > FW) ? svc_pkg::REPS_W : FW;

	// configuration registers
	logic [svc_pkg::REPS_W-1:0]  reps_q;
	logic [svc_pkg::LABEL_W-1:0] target_q;
	logic [svc_pkg::LABEL_W-1:0] nontarget_q;
	logic [svc_pkg::LABEL_W-1:0] reject_q;
	logic [svc_pkg::LABEL_W-1:0] base_q;
	logic                        choose_q;
	logic                        vmode_q;

	// queue and sequencer state
	svc_pkg::state_t state_q;
	logic [PW-1:0]   head_q [NS];
	logic [FW-1:0]   fill_q [NS];
	logic            ovf_q;
	logic [SW-1:0]   seq_src_q;
	logic [FW-1:0]   seq_rep_q;

	// result register
	logic                        out_valid_q;
	logic [svc_pkg::LABEL_W-1:0] out_label_q;
	logic [svc_pkg::TIME_W-1:0]  out_time_q;
	logic                        out_ovf_q;

	logic                               in_acc;
	logic                               have;
	logic signed [svc_pkg::SCORE_W-1:0] score;
	logic [svc_pkg::SEL_W-1:0]          src_sel;
	logic                               src_ok;
	logic [SW-1:0]                      src_idx;
	logic [SW-1:0]                      head_idx;
	logic [PW-1:0]                      head_rd;
	logic [FW-1:0]                      fill_rd;
	logic [FW-1:0]                      offset;
	logic [PW-1:0]                      slot;
	logic [AW-1:0]                      addr;
	logic                               queue_full;
	logic                               push_ok;
	logic                               push_ovf;
	logic [RW-1:0]                      reps_wide;
	logic [FW-1:0]                      reps_eff;
	logic                               all_ready;
	logic                               last_rep;
	logic                               last_src;
	logic                               emit_go;
	svc_pkg::vote_ctl_t                 vote_ctl;
	logic signed [svc_pkg::SCORE_W-1:0] rd_score;
	logic [svc_pkg::TIME_W-1:0]         rd_time;
	logic [svc_pkg::LABEL_W-1:0]        win_label;
	logic [svc_pkg::TIME_W-1:0]         win_time;

	// Add an offset to a queue pointer and wrap once around the queue
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] ptr,
		input logic [FW-1:0] off);
		logic [FW:0] s;
		s = (FW+1)'(ptr) + (FW+1)'(off);
		if (s >= (FW+1)'(QD)) begin
			s = s - (FW+1)'(QD);
		end
		return PW'(s);
	endfunction

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reps_q      <= svc_pkg::REPS_W'(1);
			target_q    <= '0;
			nontarget_q <= '0;
			reject_q    <= '0;
			base_q      <= '0;
			choose_q    <= 1'b0;
			vmode_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				svc_pkg::CFG_REPETITIONS:  reps_q      <= cfg_data[svc_pkg::REPS_W-1:0];
				svc_pkg::CFG_TARGET:       target_q    <= cfg_data;
				svc_pkg::CFG_NONTARGET:    nontarget_q <= cfg_data;
				svc_pkg::CFG_REJECT:       reject_q    <= cfg_data;
				svc_pkg::CFG_LABEL_BASE:   base_q      <= cfg_data;
				svc_pkg::CFG_CHOOSE_FIRST: choose_q    <= cfg_data[0];
				svc_pkg::CFG_VALUE_MODE:   vmode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp repetitions into one to the queue depth
	always_comb begin
		reps_wide = RW'(reps_q);
		if (reps_wide == '0) begin
			reps_wide = RW'(1);
		end else if (reps_wide > RW'(QD)) begin
			reps_wide = RW'(QD);
		end
		reps_eff = FW'(reps_wide);
	end

	// Score formation for the incoming beat
	svc_score u_score (
		.value_mode      (vmode_q),
		.target_label    (target_q),
		.nontarget_label (nontarget_q),
		.reject_label    (reject_q),
		.value_first     (value_first),
		.value_second    (value_second),
		.pair_valued     (pair_valued),
		.label_code      (label_code),
		.have            (have),
		.score           (score)
	);

	assign in_stall = (state_q != svc_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Decode the source and share one pointer lookup between push and walk
	assign src_sel  = svc_pkg::SEL_W'(source_index);
	assign src_ok   = (src_sel < svc_pkg::SEL_W'(NS));
	assign src_idx  = SW'(src_sel);
	assign head_idx = in_stall ? seq_src_q : src_idx;
	assign head_rd  = head_q[head_idx];
	assign fill_rd  = fill_q[src_idx];
	assign offset   = in_stall ? seq_rep_q : fill_rd;
	assign slot     = wrap_add(head_rd, offset);
	assign addr     = AW'(AW'(head_idx) * AW'(QD) + AW'(slot));

	assign queue_full = (fill_rd == FW'(QD));
	assign push_ok    = in_acc && have && src_ok && !queue_full;
	assign push_ovf   = in_acc && have && src_ok && queue_full;

	// Round is ready once every queue holds enough entries
	always_comb begin
		all_ready = 1'b1;
		for (int i = 0; i < NS; i++) begin
			if (fill_q[i] < reps_eff) begin
				all_ready = 1'b0;
			end
		end
	end

	assign last_rep = (seq_rep_q == reps_eff - FW'(1));
	assign last_src = (seq_src_q == SW'(NS - 1));
	assign emit_go  = (state_q == svc_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= svc_pkg::ST_IDLE;
			seq_src_q <= '0;
			seq_rep_q <= '0;
		end else begin
			unique case (state_q)
				svc_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= svc_pkg::ST_CHECK;
					end
				end
				svc_pkg::ST_CHECK: begin
					seq_src_q <= '0;
					seq_rep_q <= '0;
					state_q   <= all_ready ? svc_pkg::ST_SUM : svc_pkg::ST_IDLE;
				end
				svc_pkg::ST_SUM: begin
					if (last_rep) begin
						seq_rep_q <= '0;
						if (last_src) begin
							state_q <= svc_pkg::ST_DRAIN;
						end else begin
							seq_src_q <= seq_src_q + SW'(1);
						end
					end else begin
						seq_rep_q <= seq_rep_q + FW'(1);
					end
				end
				svc_pkg::ST_DRAIN: begin
					state_q <= svc_pkg::ST_EMIT;
				end
				svc_pkg::ST_EMIT: begin
					if (emit_go) begin
						state_q <= svc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= svc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Queue pointers: push on accept, pop the whole round while draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			ovf_q <= 1'b0;
		end else begin
			if (push_ok) begin
				fill_q[src_idx] <= fill_rd + FW'(1);
			end
			if (push_ovf) begin
				ovf_q <= 1'b1;
			end
			if (state_q == svc_pkg::ST_DRAIN) begin
				for (int i = 0; i < NS; i++) begin
					head_q[i] <= wrap_add(head_q[i], reps_eff);
					fill_q[i] <= fill_q[i] - reps_eff;
				end
			end
		end
	end

	// Score and time stores share one address
	svc_ram #(
		.WIDTH (svc_pkg::SCORE_W),
		.DEPTH (svc_pkg::ENTRIES)
	) u_score_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (addr),
		.wdata (score),
		.raddr (addr),
		.rdata (rd_score)
	);

	svc_ram #(
		.WIDTH (svc_pkg::TIME_W),
		.DEPTH (svc_pkg::ENTRIES)
	) u_time_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (addr),
		.wdata (time_stamp),
		.raddr (addr),
		.rdata (rd_time)
	);

	// Accumulator and argmax
	always_comb begin
		vote_ctl.clr  = (state_q == svc_pkg::ST_CHECK);
		vote_ctl.vld  = (state_q == svc_pkg::ST_SUM);
		vote_ctl.last = last_rep;
		vote_ctl.src  = seq_src_q;
	end

	svc_vote u_vote (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (vote_ctl),
		.rd_score     (rd_score),
		.rd_time      (rd_time),
		.label_base   (base_q),
		.reject_label (reject_q),
		.choose_first (choose_q),
		.win_label    (win_label),
		.win_time     (win_time)
	);

	// Result register: load on emit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_label_q <= win_label;
			out_time_q  <= win_time;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign class_label      = out_label_q;
	assign decision_time    = out_time_q;
	assign queue_overflowed = out_ovf_q;

endmodule

// ----- sv/svc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; sized by its WIDTH and DEPTH parameters.
`timescale 1ns / 1ps

module svc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/svc_score.sv -----
// Score former: turns one input beat into a Q16.16 score and a push flag.
// Uses svc_pkg for field widths and the one-point constant.
`timescale 1ns / 1ps

module svc_score (
	input  logic                               value_mode,
	input  logic        [svc_pkg::LABEL_W-1:0] target_label,
	input  logic        [svc_pkg::LABEL_W-1:0] nontarget_label,
	input  logic        [svc_pkg::LABEL_W-1:0] reject_label,
	input  logic signed [svc_pkg::SCORE_W-1:0] value_first,
	input  logic signed [svc_pkg::SCORE_W-1:0] value_second,
	input  logic                               pair_valued,
	input  logic        [svc_pkg::LABEL_W-1:0] label_code,
	output logic                               have,
	output logic signed [svc_pkg::SCORE_W-1:0] score
);

	localparam int W = svc_pkg::SCORE_W;

	logic signed [W:0]   a_ext;
	logic signed [W:0]   b_ext;
	logic signed [W:0]   diff;
	logic signed [W-1:0] sat;
	logic                is_target;
	logic                is_known;

	// Form negated value or first minus second, one bit wider
	always_comb begin
		a_ext = $signed({value_first[W-1], value_first});
		b_ext = $signed({value_second[W-1], value_second});
		if (pair_valued) begin
			diff = a_ext - b_ext;
		end else begin
			diff = -a_ext;
		end
	end

	// Clamp to the signed score range
	always_comb begin
		if (diff[W] != diff[W-1]) begin
			sat = diff[W] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
		end else begin
			sat = diff[W-1:0];
		end
	end

	// Label mode: target votes one point, the other known codes vote zero
	assign is_target = (label_code == target_label);
	assign is_known  = is_target || (label_code == nontarget_label)
		|| (label_code == reject_label);

	always_comb begin
		if (value_mode) begin
			have  = 1'b1;
			score = sat;
		end else begin
			have  = is_known;
			score = is_target ? $signed(svc_pkg::ONE_Q16) : '0;
		end
	end

endmodule

// ----- sv/svc_vote.sv -----
// Shared accumulator and running argmax over the stored scores.
// Uses svc_pkg for widths and the vote_ctl_t control struct.
`timescale 1ns / 1ps

module svc_vote (
	input  logic                               clk,
	input  logic                               arst_n,
	input  svc_pkg::vote_ctl_t                 ctl,
	input  logic signed [svc_pkg::SCORE_W-1:0] rd_score,
	input  logic        [svc_pkg::TIME_W-1:0]  rd_time,
	input  logic        [svc_pkg::LABEL_W-1:0] label_base,
	input  logic        [svc_pkg::LABEL_W-1:0] reject_label,
	input  logic                               choose_first,
	output logic        [svc_pkg::LABEL_W-1:0] win_label,
	output logic        [svc_pkg::TIME_W-1:0]  win_time
);

	localparam int AW = svc_pkg::ACC_W;

	svc_pkg::vote_ctl_t     ctl_s1;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   best_q;
	logic                   any_q;
	logic [svc_pkg::LABEL_W-1:0] label_q;
	logic [svc_pkg::TIME_W-1:0]  time_q;
	logic signed [AW-1:0]   sum_now;
	logic                   take_lead;
	logic                   take_tie;

	// Align control with the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	assign sum_now   = acc_q + AW'(rd_score);
	assign take_lead = !any_q || (sum_now > best_q);
	assign take_tie  = (sum_now == best_q) && !choose_first;

	// Accumulate one entry a cycle; compare at each source's last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			any_q  <= 1'b0;
		end else if (ctl.clr) begin
			acc_q  <= '0;
			any_q  <= 1'b0;
		end else if (ctl_s1.vld) begin
			if (ctl_s1.last) begin
				acc_q <= '0;
				if (take_lead) begin
					any_q <= 1'b1;
				end
			end else begin
				acc_q <= sum_now;
			end
		end
	end

	// Hold best sum, winning label and its time
	always_ff @(posedge clk) begin
		if (ctl_s1.vld && ctl_s1.last) begin
			if (take_lead) begin
				best_q  <= sum_now;
				label_q <= svc_pkg::LABEL_W'(label_base
					+ svc_pkg::LABEL_W'(ctl_s1.src));
				time_q  <= rd_time;
			end else if (take_tie) begin
				label_q <= reject_label;
				time_q  <= rd_time;
			end
		end
	end

	assign win_label = label_q;
	assign win_time  = time_q;

endmodule

// ----- sv/svc_checker.sv -----
// Port-level checker for the score voting classifier, bound to the top level.
// Uses svc_pkg widths and the assertion macros header.
`timescale 1ns / 1ps
`include "score_voting_classifier_top_macros.svh"

module svc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [svc_pkg::LABEL_W-1:0]  class_label,
	input logic                         queue_overflowed
);

	// An accepted beat keeps the block busy for at least the next cycle
	`SVC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while still checking")

	// A new decision only appears while the block is working on a beat
	`SVC_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall) && !$past(cfg_valid && cfg_ready && !in_stall), "result appeared without a beat in work")

	// Overflow flag is sticky across back-to-back results
	`SVC_ASSERT_NOW(a_overflow_sticky, out_valid && $past(out_valid) && $past(queue_overflowed), queue_overflowed, "overflow flag cleared")

	// A stalled result holds
	`SVC_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(class_label), "stalled result changed")

endmodule

bind score_voting_classifier_top svc_checker u_svc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_valid        (cfg_valid),
	.cfg_ready        (cfg_ready),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.class_label      (class_label),
	.queue_overflowed (queue_overflowed)
);
